/* rtl/scd_pkg.sv */
//------------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the dictionary spell checker core.
//------------------------------------------------------------------------------
`default_nettype none
package scd_pkg;
   localparam int MaxWordLen = 20;
   localparam int DictEntries = 4096;
   localparam int SlotW = $clog2(DictEntries);
   localparam int CharAddrW = $clog2(DictEntries * MaxWordLen);
   localparam int PosW = $clog2(MaxWordLen + 1);
   localparam int IdxW = $clog2(MaxWordLen);
   localparam logic [23:0] LineMax = 24'hFFFFFF;
   localparam logic [7:0] ChNewline = 8'd10;
   localparam logic [31:0] FnvBasis = 32'd2166136261;
   localparam logic [31:0] FnvPrime = 32'd16777619;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HASH, ST_HMUL, ST_PROBE, ST_WAIT, ST_CMP, ST_STORE, ST_EMIT
   } state_type;

   function automatic logic is_word_byte(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "-" || c == 8'h27;
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction
endpackage
`default_nettype wire

/* rtl/spell_check_tokenizer_dictionary_core.sv */
//------------------------------------------------------------------------------
// spell_check_tokenizer_dictionary_core
// Byte-serial spell checker: builds a hashed dictionary and reports
// unknown or over-long document words, one character per result.
//------------------------------------------------------------------------------
// Channel | Ports                                   | Handshake
// request | req_kind, req_char_code                 | start & !busy
// result  | rsp_report_kind, rsp_line_number,       | rsp_valid, one cycle,
//         | rsp_word_char, rsp_last                 | no back-pressure
//
// A word byte, or a separator with nothing to look up, stays in ST_IDLE.
// A word end hashes the word (FNV-1a in ST_HASH and ST_HMUL, multiply
// registered), then probes the table by linear probing: each slot reads the
// length in ST_PROBE and ST_WAIT, then compares characters in ST_CMP one at
// a time, since the character memory has one read port. A store writes one
// character a cycle, then the length; a report emits one character a cycle,
// each result registered and shown in the cycle after its emit cycle.
// After reset a clearing pass over all 4096 slots empties the table with busy high.
//------------------------------------------------------------------------------
`default_nettype none
module spell_check_tokenizer_dictionary_core import scd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   output logic             rsp_report_kind,
   output logic [23:0]      rsp_line_number,
   output logic [7:0]       rsp_word_char,
   output logic             rsp_last
);
   state_type state_ff, state_in;
   logic [7:0]  buf_ff [MaxWordLen];
   logic [15:0] wlen_ff;
   logic        digit_ff, bad_ff, doc_ff, nl_ff;
   logic [23:0] line_ff;
   logic [31:0] hash_ff, xor_ff;
   logic [PosW-1:0] pos_ff;
   logic [SlotW-1:0] slot_ff;
   logic [SlotW:0]   tries_ff;
   logic        kind_ff;
   logic        rsp_valid_ff, rsp_kind_ff, rsp_last_ff;
   logic [7:0]  rsp_char_ff;
   logic [23:0] rsp_line_ff;

   logic [PosW-1:0] len_w;
   logic [PosW-1:0] elen;
   logic            valid_q;
   logic [PosW-1:0] len_q;
   logic [7:0]      char_q;
   logic            clearing;
   logic            take;
   logic [CharAddrW-1:0] base;
   logic [CharAddrW-1:0] char_rd;
   logic [CharAddrW-1:0] char_wa;
   logic [PosW-1:0] rd_pos;
   logic [IdxW-1:0] pidx;

   assign len_w = (wlen_ff > 16'(MaxWordLen)) ? PosW'(MaxWordLen) : PosW'(wlen_ff);
   assign base  = CharAddrW'(slot_ff) * CharAddrW'(MaxWordLen);
   assign pidx  = pos_ff[IdxW-1:0];
   // Read one character ahead while comparing so char_q lines up with pos_ff.
   assign rd_pos  = (state_ff == ST_CMP) ? pos_ff + 1'b1 : pos_ff;
   assign char_rd = base + CharAddrW'(rd_pos);
   assign char_wa = base + CharAddrW'(pos_ff);
   assign elen  = kind_ff ? PosW'(MaxWordLen) : len_w;
   assign take  = start && !clearing;

   scd_store u_store (
      .clock(clock), .reset(reset),
      .slot_rd(slot_ff), .char_rd(char_rd),
      .len_we(state_ff == ST_STORE && pos_ff == len_w),
      .slot_wr(slot_ff), .len_wd(len_w),
      .char_we(state_ff == ST_STORE && pos_ff < len_w),
      .char_wr(char_wa), .char_wd(buf_ff[pidx]),
      .clearing(clearing),
      .valid_q(valid_q), .len_q(len_q), .char_q(char_q)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (!req_kind && req_char_code == ChNewline) begin
                  if (!bad_ff && wlen_ff != 16'd0 && wlen_ff <= 16'(MaxWordLen))
                     state_in = ST_HASH;
               end else if (req_kind && !is_word_byte(req_char_code)) begin
                  if (wlen_ff != 16'd0 && !digit_ff)
                     state_in = (wlen_ff > 16'(MaxWordLen)) ? ST_EMIT : ST_HASH;
               end
            end
         end
         ST_HASH:  state_in = (pos_ff == len_w) ? ST_PROBE : ST_HMUL;
         ST_HMUL:  state_in = ST_HASH;
         ST_PROBE: state_in = ST_WAIT;
         ST_WAIT: begin
            // A full table without a match: report a document word, drop a
            // dictionary word.
            if (!valid_q) state_in = doc_ff ? ST_EMIT : ST_STORE;
            else if (len_q == len_w) state_in = ST_CMP;
            else if (tries_ff == (SlotW+1)'(DictEntries - 1))
               state_in = doc_ff ? ST_EMIT : ST_IDLE;
            else state_in = ST_PROBE;
         end
         ST_CMP: begin
            if (char_q != buf_ff[pidx]) begin
               if (tries_ff == (SlotW+1)'(DictEntries - 1))
                  state_in = doc_ff ? ST_EMIT : ST_IDLE;
               else state_in = ST_PROBE;
            end else if (pos_ff == len_w - 1'b1) state_in = ST_IDLE;
         end
         ST_STORE: if (pos_ff == len_w) state_in = ST_IDLE;
         ST_EMIT:  if (pos_ff == elen - 1'b1) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wlen_ff <= '0; digit_ff <= 1'b0; bad_ff <= 1'b0;
         line_ff <= 24'd1; rsp_valid_ff <= 1'b0;
         doc_ff <= 1'b0; nl_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               pos_ff <= '0; hash_ff <= FnvBasis; tries_ff <= '0;
               kind_ff <= 1'b1;
               if (take) begin
                  doc_ff <= req_kind;
                  if (is_word_byte(req_char_code)) begin
                     if (req_kind && req_char_code >= "0" && req_char_code <= "9")
                        digit_ff <= 1'b1;
                     if (wlen_ff < 16'(MaxWordLen))
                        buf_ff[wlen_ff[IdxW-1:0]] <= fold(req_char_code);
                     if (wlen_ff != 16'hFFFF) wlen_ff <= wlen_ff + 16'd1;
                  end else if (!req_kind && req_char_code != ChNewline) begin
                     bad_ff <= 1'b1;
                  end else begin
                     // Word ends; keep length until the lookup finishes.
                     nl_ff <= req_char_code == ChNewline;
                     if (state_in == ST_IDLE) begin
                        wlen_ff <= '0; digit_ff <= 1'b0; bad_ff <= 1'b0;
                        if (req_kind && req_char_code == ChNewline && line_ff != LineMax)
                           line_ff <= line_ff + 24'd1;
                     end
                  end
               end
            end
            ST_HASH: begin
               xor_ff <= hash_ff ^ {24'd0, buf_ff[pidx]};
               if (pos_ff == len_w) slot_ff <= hash_ff[SlotW-1:0];
               else pos_ff <= pos_ff + 1'b1;
            end
            ST_HMUL: hash_ff <= xor_ff * FnvPrime;
            ST_PROBE: pos_ff <= '0;
            ST_WAIT: begin
               kind_ff <= 1'b0;
               if (valid_q && len_q != len_w) begin
                  slot_ff <= slot_ff + 1'b1; tries_ff <= tries_ff + 1'b1;
               end
            end
            ST_CMP: begin
               if (char_q != buf_ff[pidx]) begin
                  slot_ff <= slot_ff + 1'b1; tries_ff <= tries_ff + 1'b1;
                  pos_ff <= '0;
               end else pos_ff <= pos_ff + 1'b1;
            end
            ST_STORE: pos_ff <= pos_ff + 1'b1;
            ST_EMIT: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff <= kind_ff;
               rsp_line_ff <= line_ff;
               rsp_char_ff <= buf_ff[pidx];
               rsp_last_ff <= pos_ff == elen - 1'b1;
               pos_ff <= pos_ff + 1'b1;
            end
            default: ;
         endcase
         // Finish a lookup: clear the word and advance the line on a newline.
         if (state_ff != ST_IDLE && state_in == ST_IDLE) begin
            wlen_ff <= '0; digit_ff <= 1'b0; bad_ff <= 1'b0;
            if (doc_ff && nl_ff && line_ff != LineMax) line_ff <= line_ff + 24'd1;
         end
      end
   end

   // Outputs.
   always_comb begin
      busy = state_ff != ST_IDLE || clearing;
      rsp_valid = rsp_valid_ff;
      rsp_report_kind = rsp_kind_ff;
      rsp_line_number = rsp_line_ff;
      rsp_word_char = rsp_char_ff;
      rsp_last = rsp_last_ff;
   end
endmodule
`default_nettype wire

/* rtl/scd_store.sv */
//------------------------------------------------------------------------------
// scd_store
// Dictionary memories: character array and length array. A zero length
// marks an empty slot; a clearing pass after reset zeroes every length.
//------------------------------------------------------------------------------
`default_nettype none
module scd_store import scd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [SlotW-1:0]     slot_rd,
   input  wire logic [CharAddrW-1:0] char_rd,
   input  wire logic                 len_we,
   input  wire logic [SlotW-1:0]     slot_wr,
   input  wire logic [PosW-1:0]      len_wd,
   input  wire logic                 char_we,
   input  wire logic [CharAddrW-1:0] char_wr,
   input  wire logic [7:0]           char_wd,
   output logic                      clearing,
   output logic                      valid_q,
   output logic [PosW-1:0]           len_q,
   output logic [7:0]                char_q
);
   logic [7:0]      chars_mem [DictEntries*MaxWordLen];
   logic [PosW-1:0] lens_mem  [DictEntries];
   logic            clr_ff;
   logic [SlotW-1:0] clr_idx_ff;

   // Walk every slot once after reset, one slot a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= 1'b1;
         clr_idx_ff <= '0;
      end else if (clr_ff) begin
         clr_idx_ff <= clr_idx_ff + 1'b1;
         if (clr_idx_ff == SlotW'(DictEntries - 1)) clr_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (char_we) chars_mem[char_wr] <= char_wd;
      char_q <= chars_mem[char_rd];
   end

   always_ff @(posedge clock) begin
      if (clr_ff) lens_mem[clr_idx_ff] <= '0;
      else if (len_we) lens_mem[slot_wr] <= len_wd;
      len_q <= lens_mem[slot_rd];
   end

   assign clearing = clr_ff;
   assign valid_q  = len_q != '0;
endmodule
`default_nettype wire

/* tb/sv/spell_check_tokenizer_dictionary_core_tb.sv */
//------------------------------------------------------------------------------
// spell_check_tokenizer_dictionary_core_tb
// Self-checking bench: feeds dictionary and document bytes in random bursts,
// predicts every report character with a behavioral hash set and checks the
// strobed results in order against it.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
   logic        report_kind;
   logic [23:0] line_number;
   logic [7:0]  word_char;
   logic        last;
} report_char_type;

class spell_report_board;
   // behavioral copy of the checker state
   bit [7:0]    dict_text [scd_pkg::DictEntries][scd_pkg::MaxWordLen];
   int          dict_len  [scd_pkg::DictEntries];
   bit          dict_used [scd_pkg::DictEntries];
   bit [7:0]    word_buf  [scd_pkg::MaxWordLen];
   int          word_len;
   bit          word_digit;
   bit          dict_line_bad;
   bit [23:0]   line_count;
   report_char_type pending_chars[$];
   int          mismatches;

   function new();
      word_len = 0;
      word_digit = 0;
      dict_line_bad = 0;
      line_count = 1;
      mismatches = 0;
      foreach (dict_used[i]) dict_used[i] = 0;
   endfunction

   function bit word_byte(bit [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "-" || c == 8'h27;
   endfunction

   function int hash_slot();
      bit [31:0] h;
      h = 32'd2166136261;
      for (int i = 0; i < word_len && i < scd_pkg::MaxWordLen; i++) begin
         h = h ^ {24'd0, word_buf[i]};
         h = h * 32'd16777619;
      end
      return int'(h % scd_pkg::DictEntries);
   endfunction

   // return 1 if the word is present; free_slot = first empty or -1
   function bit lookup(output int free_slot);
      int slot;
      bit same;
      slot = hash_slot();
      free_slot = -1;
      for (int n = 0; n < scd_pkg::DictEntries; n++) begin
         if (!dict_used[slot]) begin
            free_slot = slot;
            return 0;
         end
         same = (dict_len[slot] == word_len);
         for (int i = 0; same && i < word_len; i++)
            if (dict_text[slot][i] != word_buf[i]) same = 0;
         if (same) return 1;
         slot = (slot + 1) % scd_pkg::DictEntries;
      end
      return 0;
   endfunction

   function void push_report(bit kind, int len);
      report_char_type r;
      for (int i = 0; i < len; i++) begin
         r.report_kind = kind;
         r.line_number = line_count;
         r.word_char = word_buf[i];
         r.last = (i == len - 1);
         pending_chars.push_back(r);
      end
   endfunction

   function void clear_word();
      word_len = 0;
      word_digit = 0;
      dict_line_bad = 0;
   endfunction

   function void append(bit [7:0] c);
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (word_len < scd_pkg::MaxWordLen) word_buf[word_len] = c;
      if (word_len < 65535) word_len++;
   endfunction

   // note one accepted request
   function void note_request(bit kind, bit [7:0] c);
      int slot;
      if (!kind) begin
         if (c == scd_pkg::ChNewline) begin
            if (!dict_line_bad && word_len >= 1 && word_len <= scd_pkg::MaxWordLen)
               if (!lookup(slot) && slot >= 0) begin
                  for (int i = 0; i < word_len; i++) dict_text[slot][i] = word_buf[i];
                  dict_len[slot] = word_len;
                  dict_used[slot] = 1;
               end
            clear_word();
         end else if (word_byte(c)) append(c);
         else dict_line_bad = 1;
         return;
      end
      if (word_byte(c)) begin
         if (c >= "0" && c <= "9") word_digit = 1;
         append(c);
         return;
      end
      if (word_len > 0 && !word_digit) begin
         if (word_len > scd_pkg::MaxWordLen) push_report(1, scd_pkg::MaxWordLen);
         else if (!lookup(slot)) push_report(0, word_len);
      end
      clear_word();
      if (c == scd_pkg::ChNewline && line_count != scd_pkg::LineMax) line_count++;
   endfunction

   // check one strobed result against the oldest expectation
   function void check_result(report_char_type got);
      report_char_type want;
      if (pending_chars.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = pending_chars.pop_front();
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: exp kind %0d line %0d char %h last %0d",
                     want.report_kind, want.line_number, want.word_char, want.last);
            $display("          got kind %0d line %0d char %h last %0d",
                     got.report_kind, got.line_number, got.word_char, got.last);
         end
      end
   endfunction
endclass

module spell_check_tokenizer_dictionary_core_tb;
   import scd_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_kind = 0;
   logic [7:0]  req_char_code = 0;
   logic        rsp_valid;
   logic        rsp_report_kind;
   logic [23:0] rsp_line_number;
   logic [7:0]  rsp_word_char;
   logic        rsp_last;

   spell_report_board board;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          sent_count = 0;
   string       dict_words[$];

   localparam int CycleLimit = 400000;

   spell_check_tokenizer_dictionary_core u_top (
      .clock, .reset, .start, .busy, .req_kind, .req_char_code,
      .rsp_valid, .rsp_report_kind, .rsp_line_number, .rsp_word_char, .rsp_last
   );

   always #10 clock = ~clock;

   // sample results and run the watchdog at every edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid)
         board.check_result({rsp_report_kind, rsp_line_number, rsp_word_char, rsp_last});
      if (cycle_count > CycleLimit) begin
         $display("spell_check_tokenizer_dictionary_core verification failed");
         $finish;
      end
   end

   // send one request; gaps come between random bursts, start holds otherwise
   task automatic send_request(input bit kind, input bit [7:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            start <= 0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1;
      req_kind <= kind;
      req_char_code <= c;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(kind, c);
      sent_count++;
   endtask

   task automatic send_line(input bit kind, input string s);
      for (int i = 0; i < s.len(); i++) send_request(kind, s[i]);
      send_request(kind, ChNewline);
   endtask

   // build a word from the common alphabet, sometimes capitalized
   function automatic string random_word(int len);
      string s;
      byte   c;
      s = "";
      for (int i = 0; i < len; i++) begin
         c = "a" + $urandom_range(0, 5);
         if ($urandom_range(0, 7) == 0) c = c - 32;
         if ($urandom_range(0, 15) == 0) c = ($urandom_range(0, 1)) ? "-" : 8'h27;
         s = {s, string'(c)};
      end
      return s;
   endfunction

   // any byte that splits document words
   function automatic bit [7:0] separator();
      bit [7:0] c;
      do c = $urandom_range(0, 255); while (board.word_byte(c));
      return c;
   endfunction

   task automatic drain();
      start <= 0;
      burst_left = 0;
      while (board.pending_chars.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      string w;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: dictionary words, case folding, rejected lines
      send_line(0, "Apple");
      send_line(0, "it's");
      send_line(0, "x-ray9");
      send_line(0, "bad word");   // rejected: holds a space
      send_request(0, ChNewline); // empty dictionary line
      send_line(0, "abcdefghijklmnopqrstu"); // over-long, not stored
      send_line(0, "apple");      // duplicate
      // document: known, unknown, digit-holding, long, separators
      send_line(1, "APPLE Zebra b4 it's");
      send_line(1, "abcdefghijklmnopqrstuvwxyz x-ray9 bad");
      send_request(1, 8'hFF);
      send_request(1, 8'h00);
      send_request(1, "z");
      send_request(1, 8'h80);
      drain(); // hold until every report is out

      while (sent_count < 420) begin
         if ($urandom_range(0, 3) == 0) begin
            w = random_word($urandom_range(1, ($urandom_range(0, 9) == 0) ? 22 : 5));
            if ($urandom_range(0, 9) == 0) w = {w, string'(separator())};
            if ($urandom_range(0, 11) == 0) w = {w, "7"};
            dict_words.push_back(w);
            send_line(0, w);
         end else begin
            if (dict_words.size() != 0 && $urandom_range(0, 1))
               w = dict_words[$urandom_range(0, dict_words.size() - 1)];
            else
               w = random_word($urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4));
            if ($urandom_range(0, 15) == 0) w = {w, "3"};
            for (int i = 0; i < w.len(); i++) send_request(1, w[i]);
            send_request(1, ($urandom_range(0, 2) == 0) ? ChNewline : separator());
         end
      end
      send_request(1, ChNewline);
      drain();

      if (board.mismatches == 0 && board.pending_chars.size() == 0)
         $display("spell_check_tokenizer_dictionary_core verification clean");
      else
         $display("spell_check_tokenizer_dictionary_core verification failed");
      $finish;
   end
endmodule
